// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the fill-ratio checker.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: condition violated");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/qfr_pkg.sv =====
// Package of the quadrilateral fill-ratio checker: widths, register codes,
// and the per-edge term passed from the edge units to the top level.
`default_nettype none

package qfr_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam int GRAY_W     = 8;
  localparam int VERT_W     = 24;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 25;
  localparam int NUM_EDGES  = 4;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int EPROD_W    = 2 * DIFF_W;
  localparam int RATIO_W    = CNT_W + PCT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VERT_W;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT = 3'd6;

  localparam logic [GRAY_W-1:0] GRAY_HIGH_RST = {GRAY_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [PCT_W-1:0]  PERCENT_FULL  = 7'd100;

  // One edge against one pixel row: active when the edge is not horizontal and
  // the row lies in its closed y range; lhs/rhs are the two cross-product halves.
  typedef struct packed {
    logic                      active;
    logic                      dy_pos;
    logic signed [EPROD_W-1:0] lhs;
    logic signed [EPROD_W-1:0] rhs;
  } edge_term_t;

endpackage

`default_nettype wire

// ===== hdl/qfr_if.sv =====
// Stream interfaces of the fill-ratio checker: pixel channel and result channel.
// Depends on qfr_pkg for the field widths.
`default_nettype none

interface qfr_pixel_if;
  import qfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [GRAY_W-1:0] gray;
  logic              last;

  modport source (output valid, pixel_x, pixel_y, gray, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, gray, last, output ready);
endinterface

interface qfr_result_if;
  import qfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] inside_count;
  logic [CNT_W-1:0] match_count;
  logic             accept;

  modport source (output valid, inside_count, match_count, accept, input ready);
  modport sink   (input valid, inside_count, match_count, accept, output ready);
endinterface

`default_nettype wire

// ===== hdl/qfr_edge.sv =====
// Ray-crossing terms of one quadrilateral edge for one pixel: y-range check
// and the two exact cross-product halves. Depends on qfr_pkg.
`default_nettype none

module qfr_edge (
  input  wire logic [qfr_pkg::COORD_BITS-1:0] xs,
  input  wire logic [qfr_pkg::COORD_BITS-1:0] ys,
  input  wire logic [qfr_pkg::COORD_BITS-1:0] xe,
  input  wire logic [qfr_pkg::COORD_BITS-1:0] ye,
  input  wire logic [qfr_pkg::COORD_BITS-1:0] px,
  input  wire logic [qfr_pkg::COORD_BITS-1:0] py,
  output qfr_pkg::edge_term_t                 term
);
  import qfr_pkg::*;

  logic signed [DIFF_W-1:0]     dy;
  logic signed [DIFF_W-1:0]     dx;
  logic signed [DIFF_W-1:0]     rel_y;
  logic signed [DIFF_W-1:0]     rel_x;
  logic [COORD_BITS-1:0]        y_lo;
  logic [COORD_BITS-1:0]        y_hi;

  assign dy    = $signed({1'b0, ye}) - $signed({1'b0, ys});
  assign dx    = $signed({1'b0, xe}) - $signed({1'b0, xs});
  assign rel_y = $signed({1'b0, py}) - $signed({1'b0, ys});
  assign rel_x = $signed({1'b0, px}) - $signed({1'b0, xs});

  assign y_lo = (ys < ye) ? ys : ye;
  assign y_hi = (ys < ye) ? ye : ys;

  always_comb begin
    term.active = (dy != '0) && (py >= y_lo) && (py <= y_hi);
    term.dy_pos = !dy[DIFF_W-1];
    term.lhs    = EPROD_W'(rel_y) * EPROD_W'(dx);
    term.rhs    = EPROD_W'(rel_x) * EPROD_W'(dy);
  end

endmodule

`default_nettype wire

// ===== hdl/quad_fill_ratio_check.sv =====
// Fill-ratio check of a pixel stream against a configured quadrilateral.
// Throughput: one pixel per cycle; the input stalls only while a last pixel waits for room.
// A last pixel's result passes through the registers in order (input reg, edge products,
// count update, ratio products, result reg).
// Reset (rst, synchronous): counters and stage valids clear, vertices 0,
// grey window 0..255, minimum percent 0.
`default_nettype none

`include "assert_macros.svh"

module quad_fill_ratio_check (
  input  wire logic                          clk,
  input  wire logic                          rst,
  qfr_pixel_if.sink                          pixel_in,
  qfr_result_if.source                       result_out,
  input  wire logic                          wr_en,
  input  wire logic [qfr_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [qfr_pkg::CFG_DATA_W-1:0] wr_data
);
  import qfr_pkg::*;

  // configuration
  logic [VERT_W-1:0] vertex [NUM_EDGES];
  logic [GRAY_W-1:0] gray_low;
  logic [GRAY_W-1:0] gray_high;
  logic [PCT_W-1:0]  min_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_EDGES; i++) vertex[i] <= '0;
      gray_low    <= '0;
      gray_high   <= GRAY_HIGH_RST;
      min_percent <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_VERTEX_A:    vertex[0]   <= wr_data[VERT_W-1:0];
        REG_VERTEX_B:    vertex[1]   <= wr_data[VERT_W-1:0];
        REG_VERTEX_C:    vertex[2]   <= wr_data[VERT_W-1:0];
        REG_VERTEX_D:    vertex[3]   <= wr_data[VERT_W-1:0];
        REG_GRAY_LOW:    gray_low    <= wr_data[GRAY_W-1:0];
        REG_GRAY_HIGH:   gray_high   <= wr_data[GRAY_W-1:0];
        REG_MIN_PERCENT: min_percent <= wr_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COORD_BITS-1:0] vx [NUM_EDGES];
  logic [COORD_BITS-1:0] vy [NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      vx[i] = vertex[i][2*COORD_BITS-1:COORD_BITS];
      vy[i] = vertex[i][COORD_BITS-1:0];
    end
  end

  // stage handshake
  logic p_valid, e_valid, f_valid, m_valid, o_valid;
  logic p_free, e_free, f_free, m_free, o_free;
  logic p_go, e_go, f_go, m_go;
  logic e_last;

  assign o_free = !o_valid || result_out.ready;
  assign m_go   = m_valid && o_free;
  assign m_free = !m_valid || m_go;
  assign f_go   = f_valid && m_free;
  assign f_free = !f_valid || f_go;
  // only a last pixel needs room further down
  assign e_go   = e_valid && (!e_last || f_free);
  assign e_free = !e_valid || e_go;
  assign p_go   = p_valid && e_free;
  assign p_free = !p_valid || p_go;

  assign pixel_in.ready = p_free;

  // input register
  logic [COORD_BITS-1:0] p_x;
  logic [COORD_BITS-1:0] p_y;
  logic [GRAY_W-1:0]     p_gray;
  logic                  p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && pixel_in.valid) begin
      p_x    <= pixel_in.pixel_x[COORD_BITS-1:0];
      p_y    <= pixel_in.pixel_y[COORD_BITS-1:0];
      p_gray <= pixel_in.gray;
      p_last <= pixel_in.last;
    end
  end

  // geometry of the registered pixel
  edge_term_t term [NUM_EDGES];

  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_edge
    qfr_edge u_edge (
      .xs   (vx[i]),
      .ys   (vy[i]),
      .xe   (vx[(i + 1) % NUM_EDGES]),
      .ye   (vy[(i + 1) % NUM_EDGES]),
      .px   (p_x),
      .py   (p_y),
      .term (term[i])
    );
  end

  logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic                  box_hit;
  logic                  gray_hit;

  always_comb begin
    min_x = vx[0];
    max_x = vx[0];
    min_y = vy[0];
    max_y = vy[0];
    for (int i = 1; i < NUM_EDGES; i++) begin
      if (vx[i] < min_x) min_x = vx[i];
      if (vx[i] > max_x) max_x = vx[i];
      if (vy[i] < min_y) min_y = vy[i];
      if (vy[i] > max_y) max_y = vy[i];
    end
    box_hit  = (p_x >= min_x) && (p_x <= max_x) && (p_y >= min_y) && (p_y <= max_y);
    gray_hit = (p_gray >= gray_low) && (p_gray <= gray_high);
  end

  // edge product register
  edge_term_t e_term [NUM_EDGES];
  logic       e_box;
  logic       e_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_free) begin
      e_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free && p_valid) begin
      e_term <= term;
      e_box  <= box_hit;
      e_gray <= gray_hit;
      e_last <= p_last;
    end
  end

  // crossing parity and count update
  logic [NUM_EDGES-1:0] edge_cross;
  logic                 inside_hit;
  logic [CNT_W-1:0]     inside_cnt, match_cnt;
  logic [CNT_W-1:0]     inside_cnt_next, match_cnt_next;

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      edge_cross[i] = e_term[i].active &&
                      (e_term[i].dy_pos ? ($signed(e_term[i].lhs) > $signed(e_term[i].rhs))
                                        : ($signed(e_term[i].lhs) < $signed(e_term[i].rhs)));
    end
    inside_hit = e_box && (^edge_cross);

    inside_cnt_next = inside_cnt;
    match_cnt_next  = match_cnt;
    if (inside_hit) begin
      if (inside_cnt != CNT_MAX) inside_cnt_next = inside_cnt + 1'b1;
      if (e_gray && (match_cnt != CNT_MAX)) match_cnt_next = match_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_cnt <= '0;
      match_cnt  <= '0;
    end else if (e_go) begin
      // clear after the scan closes
      inside_cnt <= e_last ? '0 : inside_cnt_next;
      match_cnt  <= e_last ? '0 : match_cnt_next;
    end
  end

  // final count register
  logic [CNT_W-1:0] f_inside, f_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_free) begin
      f_valid <= e_go && e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (f_free && e_go && e_last) begin
      f_inside <= inside_cnt_next;
      f_match  <= match_cnt_next;
    end
  end

  // ratio product register
  logic [CNT_W-1:0]   m_inside, m_match;
  logic [RATIO_W-1:0] m_lhs, m_rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_go) begin
      m_inside <= f_inside;
      m_match  <= f_match;
      m_lhs    <= RATIO_W'(f_match) * RATIO_W'(PERCENT_FULL);
      m_rhs    <= RATIO_W'(min_percent) * RATIO_W'(f_inside);
    end
  end

  // result register
  logic [CNT_W-1:0] o_inside, o_match;
  logic             o_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_go) begin
      o_inside <= m_inside;
      o_match  <= m_match;
      o_accept <= (m_inside != '0) && (m_lhs >= m_rhs);
    end
  end

  assign result_out.valid        = o_valid;
  assign result_out.inside_count = o_inside;
  assign result_out.match_count  = o_match;
  assign result_out.accept       = o_accept;

  `ASSERT_ALWAYS(a_match_le_inside, clk, rst, match_cnt <= inside_cnt)
  `ASSERT_NEXT(a_clear_after_last, clk, rst, e_go && e_last,
               (inside_cnt == '0) && (match_cnt == '0))
  `ASSERT_IMPLY(a_accept_nonempty, clk, rst, o_valid && o_accept, o_inside != '0)

endmodule

`default_nettype wire

// ===== bench/tb_quad_fill_ratio_check.sv =====
// Testbench for quad_fill_ratio_check: drives pixel scans against a range of
// quadrilateral and grey-window settings and checks every count/accept result.
// Depends on qfr_pkg and the qfr_pixel_if / qfr_result_if interfaces.
module tb_quad_fill_ratio_check;
  timeunit 1ns;
  timeprecision 1ps;

  import qfr_pkg::*;

  localparam int IDLE_PCT       = 25;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int STALL_CYCLES   = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PRESSURE_ITEMS = 40;
  localparam int NUM_REGS       = 7;
  localparam int SPREAD         = 40;
  localparam int BOX_MARGIN     = 2;
  localparam int MAX_COORD      = (1 << COORD_BITS) - 1;
  localparam int MAX_GRAY       = (1 << GRAY_W) - 1;
  localparam int MAX_PCT        = (1 << PCT_W) - 1;

  typedef struct {
    logic [CNT_W-1:0] inside_count;
    logic [CNT_W-1:0] match_count;
    logic             accept;
  } tally_t;

  class fill_ratio_scoreboard;
    localparam int COORD_MASK = (1 << COORD_BITS) - 1;

    logic [VERT_W-1:0] corner [NUM_EDGES];
    logic [GRAY_W-1:0] gray_lo;
    logic [GRAY_W-1:0] gray_hi;
    logic [PCT_W-1:0]  min_pct;
    logic [CNT_W-1:0]  inside_run;
    logic [CNT_W-1:0]  match_run;
    tally_t            tally_q [$];
    int                errors;

    function new();
      foreach (corner[k]) corner[k] = '0;
      gray_lo    = '0;
      gray_hi    = GRAY_HIGH_RST;
      min_pct    = '0;
      inside_run = '0;
      match_run  = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VERTEX_A:    corner[0] = data[VERT_W-1:0];
        REG_VERTEX_B:    corner[1] = data[VERT_W-1:0];
        REG_VERTEX_C:    corner[2] = data[VERT_W-1:0];
        REG_VERTEX_D:    corner[3] = data[VERT_W-1:0];
        REG_GRAY_LOW:    gray_lo = data[GRAY_W-1:0];
        REG_GRAY_HIGH:   gray_hi = data[GRAY_W-1:0];
        REG_MIN_PERCENT: min_pct = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // Bounding box, then ray-crossing parity over the four closed edges.
    function bit covers(int px, int py);
      int vx [NUM_EDGES];
      int vy [NUM_EDGES];
      int xmin, xmax, ymin, ymax;
      int xs, ys, xe, ye, dy;
      longint lhs, rhs;
      int hits;
      hits = 0;
      for (int i = 0; i < NUM_EDGES; i++) begin
        vx[i] = int'(corner[i][2*COORD_BITS-1:COORD_BITS]);
        vy[i] = int'(corner[i][COORD_BITS-1:0]);
      end
      xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
      for (int i = 1; i < NUM_EDGES; i++) begin
        if (vx[i] < xmin) xmin = vx[i];
        if (vx[i] > xmax) xmax = vx[i];
        if (vy[i] < ymin) ymin = vy[i];
        if (vy[i] > ymax) ymax = vy[i];
      end
      if (px < xmin || px > xmax || py < ymin || py > ymax) return 1'b0;
      for (int i = 0; i < NUM_EDGES; i++) begin
        xs = vx[i];
        ys = vy[i];
        xe = vx[(i + 1) % NUM_EDGES];
        ye = vy[(i + 1) % NUM_EDGES];
        dy = ye - ys;
        if (dy == 0) continue;
        if (py < ((ys < ye) ? ys : ye) || py > ((ys < ye) ? ye : ys)) continue;
        // compare crossing x against px without dividing by dy
        lhs = longint'(py - ys) * longint'(xe - xs);
        rhs = longint'(px - xs) * longint'(dy);
        if ((dy > 0) ? (lhs > rhs) : (lhs < rhs)) hits++;
      end
      return hits[0];
    endfunction

    function void note_pixel(int x, int y, int g, bit last);
      tally_t t;
      if (covers(x & COORD_MASK, y & COORD_MASK)) begin
        if (inside_run != CNT_MAX) inside_run++;
        if (g >= gray_lo && g <= gray_hi && match_run != CNT_MAX) match_run++;
      end
      if (last) begin
        t.inside_count = inside_run;
        t.match_count  = match_run;
        t.accept = (inside_run != 0) &&
                   (longint'(match_run) * PERCENT_FULL >= longint'(min_pct) * inside_run);
        tally_q.push_back(t);
        inside_run = '0;
        match_run  = '0;
      end
    endfunction

    function int pending();
      return tally_q.size();
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_tally(logic [CNT_W-1:0] got_inside, logic [CNT_W-1:0] got_match, logic acc);
      tally_t t;
      if (tally_q.size() == 0) begin
        report($sformatf("result with nothing pending: inside %0d match %0d accept %0b",
                         got_inside, got_match, acc));
        return;
      end
      t = tally_q.pop_front();
      if (got_inside !== t.inside_count)
        report($sformatf("inside_count %0d, want %0d", got_inside, t.inside_count));
      if (got_match !== t.match_count)
        report($sformatf("match_count %0d, want %0d", got_match, t.match_count));
      if (acc !== t.accept)
        report($sformatf("accept %0b, want %0b (inside %0d match %0d)",
                         acc, t.accept, t.inside_count, t.match_count));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  qfr_pixel_if  pix ();
  qfr_result_if res ();

  fill_ratio_scoreboard sb = new();

  bit calm;
  int stall_asks;
  int sent;
  int qx [NUM_EDGES];
  int qy [NUM_EDGES];
  int box_x0, box_x1, box_y0, box_y1;

  quad_fill_ratio_check u_top (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pix),
    .result_out (res),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_quad_fill_ratio_check: errors");
    $finish;
  end

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > MAX_COORD) ? MAX_COORD : v);
  endfunction

  task automatic send_pixel(int x, int y, int g, bit last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= PIX_W'(x);
    pix.pixel_y <= PIX_W'(y);
    pix.gray    <= GRAY_W'(g);
    pix.last    <= last;
    do @(posedge clk); while (pix.ready !== 1'b1);
    sb.note_pixel(x, y, g, last);
    sent++;
  endtask

  // Mostly pixels around the quadrilateral, some anywhere in the frame.
  task automatic send_scan(int n);
    int x, y;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 80) begin
        x = $urandom_range(box_x1, box_x0);
        y = $urandom_range(box_y1, box_y0);
      end else begin
        x = $urandom_range(MAX_COORD);
        y = $urandom_range(MAX_COORD);
      end
      send_pixel(x, y, $urandom_range(MAX_GRAY), k == n - 1);
    end
  endtask

  // Hold the input until every pending result is out and the pipeline is empty.
  task automatic drain();
    pix.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(int lo, int hi, int pct);
    logic [CFG_DATA_W-1:0] val [NUM_REGS];
    for (int k = 0; k < NUM_EDGES; k++)
      val[int'(REG_VERTEX_A) + k] = {COORD_BITS'(qx[k]), COORD_BITS'(qy[k])};
    val[REG_GRAY_LOW]    = CFG_DATA_W'(lo);
    val[REG_GRAY_HIGH]   = CFG_DATA_W'(hi);
    val[REG_MIN_PERCENT] = CFG_DATA_W'(pct);
    for (int r = 0; r < NUM_REGS; r++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_IDX_W'(r);
      wr_data  <= val[r];
      sb.set_reg(CFG_IDX_W'(r), val[r]);
      @(posedge clk);
    end
    wr_en <= 1'b0;
    box_x0 = qx[0]; box_x1 = qx[0]; box_y0 = qy[0]; box_y1 = qy[0];
    for (int k = 1; k < NUM_EDGES; k++) begin
      if (qx[k] < box_x0) box_x0 = qx[k];
      if (qx[k] > box_x1) box_x1 = qx[k];
      if (qy[k] < box_y0) box_y0 = qy[k];
      if (qy[k] > box_y1) box_y1 = qy[k];
    end
    box_x0 = clamp_coord(box_x0 - BOX_MARGIN);
    box_x1 = clamp_coord(box_x1 + BOX_MARGIN);
    box_y0 = clamp_coord(box_y0 - BOX_MARGIN);
    box_y1 = clamp_coord(box_y1 + BOX_MARGIN);
  endtask

  // Result side: check each transfer, stall on request, otherwise idle at random.
  initial begin : result_sink
    int hold_left;
    int stalls_done;
    hold_left   = 0;
    stalls_done = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid === 1'b1 && res.ready === 1'b1)
        sb.check_tally(res.inside_count, res.match_count, res.accept);
      if (hold_left == 0 && stalls_done != stall_asks) begin
        hold_left   = STALL_CYCLES;
        stalls_done = stall_asks;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int base, phase, mode, cx, cy, step, lo, hi, pct, pick, tmp;
    calm       = 1'b0;
    stall_asks = 0;
    sent       = 0;
    rst         <= 1'b1;
    wr_en       <= 1'b0;
    wr_index    <= '0;
    wr_data     <= '0;
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    pix.gray    <= '0;
    pix.last    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: all vertices at the origin, so nothing is inside.
    box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0;
    send_pixel(0, 0, 0, 1'b1);
    send_pixel(MAX_COORD, MAX_COORD, MAX_GRAY, 1'b1);

    // Square with edges and corners, grey values around the window.
    drain();
    qx = '{100, 200, 200, 100};
    qy = '{100, 100, 200, 200};
    load_setting(50, 150, 50);
    send_pixel(150, 150, 100, 1'b0);
    send_pixel(100, 100, 50, 1'b0);
    send_pixel(200, 200, 150, 1'b0);
    send_pixel(150, 150, 49, 1'b0);
    send_pixel(150, 150, 151, 1'b0);
    send_pixel(0, 0, 0, 1'b0);
    send_pixel(MAX_COORD, MAX_COORD, MAX_GRAY, 1'b1);

    // Crossed grey window: nothing matches, zero percent still accepts.
    drain();
    load_setting(200, 10, 0);
    send_pixel(150, 150, 100, 1'b0);
    send_pixel(120, 180, 200, 1'b1);

    // Full-frame quadrilateral with a percentage above a hundred.
    drain();
    qx = '{0, MAX_COORD, MAX_COORD, 0};
    qy = '{0, 0, MAX_COORD, MAX_COORD};
    load_setting(0, MAX_GRAY, MAX_PCT);
    send_pixel(0, 0, 0, 1'b0);
    send_pixel(MAX_COORD, MAX_COORD, MAX_GRAY, 1'b0);
    send_pixel(MAX_COORD / 2, MAX_COORD / 2, 128, 1'b0);
    send_pixel(MAX_COORD, 0, 7, 1'b1);

    drain();
    load_setting(0, MAX_GRAY - 1, PERCENT_FULL);
    send_pixel(1000, 1000, MAX_GRAY, 1'b0);
    send_pixel(1000, 1001, MAX_GRAY - 1, 1'b1);

    // Coincident vertices, then an outline that is all horizontal.
    drain();
    qx = '{10, 10, 50, 10};
    qy = '{10, 10, 50, 50};
    load_setting(0, MAX_GRAY, 30);
    send_pixel(20, 40, 5, 1'b1);
    send_pixel(30, 30, 5, 1'b1);

    drain();
    qx = '{0, MAX_COORD, 2000, 7};
    qy = '{300, 300, 300, 300};
    load_setting(0, MAX_GRAY, 0);
    send_pixel(500, 300, 9, 1'b1);

    base  = sent;
    phase = 0;
    while (sent < base + RANDOM_ITEMS) begin
      drain();
      calm = (phase >= 12 && phase < 18);
      mode = $urandom_range(9);
      cx   = $urandom_range(MAX_COORD);
      cy   = $urandom_range(MAX_COORD);
      step = $urandom_range(2 * SPREAD) - SPREAD;
      for (int k = 0; k < NUM_EDGES; k++) begin
        if (mode < 6) begin
          qx[k] = clamp_coord(cx + $urandom_range(2 * SPREAD) - SPREAD);
          qy[k] = clamp_coord(cy + $urandom_range(2 * SPREAD) - SPREAD);
        end else if (mode == 6) begin
          qx[k] = $urandom_range(MAX_COORD);
          qy[k] = $urandom_range(MAX_COORD);
        end else if (mode == 7) begin
          qx[k] = $urandom_range(1) ? MAX_COORD : 0;
          qy[k] = $urandom_range(1) ? MAX_COORD : 0;
        end else if (mode == 8) begin
          qx[k] = clamp_coord(cx + $urandom_range(2 * SPREAD) - SPREAD);
          qy[k] = cy;
        end else begin
          qx[k] = clamp_coord(cx + k * step);
          qy[k] = clamp_coord(cy + k * step);
        end
      end
      lo = $urandom_range(MAX_GRAY);
      hi = $urandom_range(MAX_GRAY, lo);
      if ($urandom_range(99) < 15) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      pick = $urandom_range(19);
      if (pick == 0) pct = 0;
      else if (pick == 1) pct = PERCENT_FULL;
      else if (pick == 2) pct = $urandom_range(MAX_PCT, PERCENT_FULL + 1);
      else pct = $urandom_range(PERCENT_FULL);
      if (pick == 3) begin
        lo = 0;
        hi = MAX_GRAY;
      end
      load_setting(lo, hi, pct);

      if (phase == 4) begin
        // stall the result side while single-pixel scans keep coming
        calm = 1'b1;
        stall_asks++;
        repeat (PRESSURE_ITEMS) send_scan(1);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_scan($urandom_range(30, 1));
          if ($urandom_range(9) == 0) drain();
        end
      end
      phase++;
    end

    calm = 1'b0;
    drain();
    if (sb.errors == 0)
      $display("tb_quad_fill_ratio_check: clean");
    else
      $display("tb_quad_fill_ratio_check: errors");
    $finish;
  end

endmodule
